@@ design/grid_overlap_downsampler_defines.svh @@
// Shared assertion macros for the downsampler.
`ifndef GRID_OVERLAP_DOWNSAMPLER_DEFINES_SVH
`define GRID_OVERLAP_DOWNSAMPLER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define GDSMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define GDSMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/gdsmp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gdsmp_pkg;

  localparam int FINE_COLS_MAX = 256;
  localparam int FINE_ROWS_MAX = 256;
  localparam int FRACTION_BITS = 10;

  localparam int COL_W  = $clog2(FINE_COLS_MAX);
  localparam int ROW_W  = $clog2(FINE_ROWS_MAX);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = FINE_COLS_MAX * FINE_ROWS_MAX;

  // Divider quotient clamps at the larger grid size
  localparam int DIV_LIM = (FINE_COLS_MAX > FINE_ROWS_MAX) ? FINE_COLS_MAX : FINE_ROWS_MAX;
  localparam int DQ_W    = $clog2(DIV_LIM);
  localparam int CNT_W   = DQ_W + 1;
  localparam int STEP_W  = $clog2(DQ_W + 1);

  localparam int RES_W   = 16;
  localparam int OFF_W   = 32;
  localparam int CIDX_W  = 12;
  localparam int FIDX_W  = 8;
  localparam int POS_W   = 34;
  localparam int REM_W   = RES_W + DQ_W;
  localparam int PX_W    = CNT_W + RES_W;
  localparam int AREA_W  = 2 * RES_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int GCOUNT_W  = 9;
  localparam int IN_W      = 48;
  localparam int OCC_W     = 8;

  localparam logic [RES_W-1:0] RST_FRES = RES_W'(1 << FRACTION_BITS);
  localparam logic [RES_W-1:0] RST_CRES = RES_W'(4 << FRACTION_BITS);
  localparam logic [GCOUNT_W-1:0] RST_COUNT = GCOUNT_W'(256);

  localparam logic [1:0] CELL_UNKNOWN = 2'd0;
  localparam logic [1:0] CELL_FREE    = 2'd1;
  localparam logic [1:0] CELL_BLOCKED = 2'd2;

  localparam logic [OCC_W-1:0] OCC_FREE    = 8'd0;
  localparam logic [OCC_W-1:0] OCC_BLOCKED = 8'd100;
  localparam logic [OCC_W-1:0] OCC_UNKNOWN = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_OFF_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd5;

  typedef enum logic [1:0] {DIV_XLO, DIV_XHI, DIV_YLO, DIV_YHI} div_sel_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SPAN_LO, ST_SPAN_HI, ST_DIV_GO, ST_DIV_WAIT,
    ST_BASE, ST_READ, ST_EVAL, ST_DONE
  } state_t;

  typedef struct packed {
    logic     clr_we;
    logic     load_we;
    logic     query_go;
    logic     span_lo;
    logic     span_hi;
    logic     div_start;
    div_sel_t div_sel;
    logic     base;
    logic     rd_en;
    logic     eval;
    logic     step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic div_busy;
    logic empty;
    logic x_last;
    logic y_last;
    logic cell_free;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ design/gdsmp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gdsmp_div import gdsmp_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [POS_W-1:0] v,
  input  wire logic [RES_W-1:0]        d,
  output logic                         busy,
  output logic                         done,
  output logic [CNT_W-1:0]             q
);

  logic              busy_r, done_r, neg_r, sat_r;
  logic [STEP_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [DQ_W-1:0]   q_r;
  logic [REM_W:0]    trial;
  logic              sat_now;

  // Quotient at or above the limit saturates
  assign sat_now = v >= $signed(POS_W'({d, {DQ_W{1'b0}}}));
  assign trial   = {1'b0, rem_r} - {1'b0, (REM_W'(d) << cnt_r)};

  // Control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Restoring division datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= v[POS_W-1];
      sat_r <= sat_now;
      rem_r <= REM_W'(v);
      q_r   <= '0;
      cnt_r <= STEP_W'(DQ_W - 1);
    end else if (busy_r) begin
      if (!trial[REM_W]) begin
        rem_r <= trial[REM_W-1:0];
      end
      q_r   <= DQ_W'({q_r, !trial[REM_W]});
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign q    = neg_r ? '0 : (sat_r ? CNT_W'(DIV_LIM) : {1'b0, q_r});

endmodule
`default_nettype wire

@@ design/gdsmp_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gdsmp_dp import gdsmp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_DAT_W-1:0] cfg_dat,
  input  wire logic [FIDX_W-1:0]    in_fine_col,
  input  wire logic [FIDX_W-1:0]    in_fine_row,
  input  wire logic [1:0]           in_fine_state,
  input  wire logic [CIDX_W-1:0]    in_coarse_col,
  input  wire logic [CIDX_W-1:0]    in_coarse_row,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [OCC_W-1:0]          out_occupancy
);

  // Configuration registers
  logic signed [OFF_W-1:0] off_x_r, off_y_r;
  logic [RES_W-1:0]        fres_r, cres_r;
  logic [GCOUNT_W-1:0]     cols_r, rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      fres_r  <= RST_FRES;
      cres_r  <= RST_CRES;
      cols_r  <= RST_COUNT;
      rows_r  <= RST_COUNT;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OFF_X: off_x_r <= $signed(cfg_dat);
        REG_OFF_Y: off_y_r <= $signed(cfg_dat);
        REG_FRES:  fres_r  <= cfg_dat[RES_W-1:0];
        REG_CRES:  cres_r  <= cfg_dat[RES_W-1:0];
        REG_COLS:  cols_r  <= cfg_dat[GCOUNT_W-1:0];
        REG_ROWS:  rows_r  <= cfg_dat[GCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [RES_W-1:0] fres, cres;
  logic [CNT_W-1:0] ncol, nrow;

  // Zero resolution acts as one; grid size clamps to the store
  assign fres = (fres_r == '0) ? RES_W'(1) : fres_r;
  assign cres = (cres_r == '0) ? RES_W'(1) : cres_r;
  assign ncol = (int'(cols_r) > FINE_COLS_MAX) ? CNT_W'(FINE_COLS_MAX) : CNT_W'(cols_r);
  assign nrow = (int'(rows_r) > FINE_ROWS_MAX) ? CNT_W'(FINE_ROWS_MAX) : CNT_W'(rows_r);

  // Cell store with clearing pass
  logic [1:0]        mem [0:DEPTH-1];
  logic [ADDR_W-1:0] clr_cnt_r, wr_addr, rd_addr;
  logic [1:0]        wr_data, rd_q;
  logic              wr_en, load_ok;
  logic [CNT_W-1:0]  fx_r, fy_r;

  assign load_ok = (int'(in_fine_col) < FINE_COLS_MAX) && (int'(in_fine_row) < FINE_ROWS_MAX);
  assign wr_en   = cmd.clr_we || (cmd.load_we && load_ok);
  assign wr_addr = cmd.clr_we ? clr_cnt_r : {ROW_W'(in_fine_row), COL_W'(in_fine_col)};
  assign wr_data = cmd.clr_we ? CELL_UNKNOWN : in_fine_state;
  assign rd_addr = {fy_r[ROW_W-1:0], fx_r[COL_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Coarse span on both axes
  logic [CIDX_W-1:0]          ccol_r, crow_r;
  logic signed [POS_W-1:0]    xlo_r, xhi_r, ylo_r, yhi_r;
  logic [CIDX_W+RES_W-1:0]    prod_x, prod_y;
  logic [2*RES_W-1:0]         cres_sq, cres_sq_r;

  assign prod_x  = ccol_r * cres;
  assign prod_y  = crow_r * cres;
  assign cres_sq = cres * cres;

  always_ff @(posedge clk) begin
    if (cmd.query_go) begin
      ccol_r <= in_coarse_col;
      crow_r <= in_coarse_row;
    end
    if (cmd.span_lo) begin
      xlo_r     <= POS_W'(off_x_r) + $signed(POS_W'(prod_x));
      ylo_r     <= POS_W'(off_y_r) + $signed(POS_W'(prod_y));
      cres_sq_r <= cres_sq;
    end
    if (cmd.span_hi) begin
      xhi_r <= xlo_r + $signed(POS_W'(cres));
      yhi_r <= ylo_r + $signed(POS_W'(cres));
    end
  end

  // Fine index bounds through the shared divider
  logic signed [POS_W-1:0] div_v;
  logic                    div_busy, div_done;
  logic [CNT_W-1:0]        div_q;
  logic [CNT_W:0]          q_up;
  div_sel_t                dsel_r;
  logic [CNT_W-1:0]        xb_r, xe_r, yb_r, ye_r;

  always_comb begin
    case (cmd.div_sel)
      DIV_XLO: div_v = xlo_r;
      DIV_XHI: div_v = xhi_r - $signed(POS_W'(1));
      DIV_YLO: div_v = ylo_r;
      DIV_YHI: div_v = yhi_r - $signed(POS_W'(1));
      default: div_v = xlo_r;
    endcase
  end

  gdsmp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .v     (div_v),
    .d     (fres),
    .busy  (div_busy),
    .done  (div_done),
    .q     (div_q)
  );

  assign q_up = {1'b0, div_q} + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dsel_r <= cmd.div_sel;
    end
    if (div_done) begin
      case (dsel_r)
        DIV_XLO: xb_r <= (div_q > ncol) ? ncol : div_q;
        DIV_XHI: xe_r <= (xhi_r <= 0) ? '0 :
                         ((q_up > {1'b0, ncol}) ? ncol : q_up[CNT_W-1:0]);
        DIV_YLO: yb_r <= (div_q > nrow) ? nrow : div_q;
        DIV_YHI: ye_r <= (yhi_r <= 0) ? '0 :
                         ((q_up > {1'b0, nrow}) ? nrow : q_up[CNT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Walk position and per-cell overlap
  logic [PX_W-1:0]         xbase_r, xpos_r, ypos_r;
  logic signed [POS_W-1:0] xc_lo, xc_hi, yc_lo, yc_hi, xo_lo, xo_hi, yo_lo, yo_hi, dx, dy;
  logic [RES_W-1:0]        ox_r, oy_r;
  logic                    ox_ok_r, oy_ok_r;

  assign xc_lo = $signed(POS_W'(xpos_r));
  assign xc_hi = $signed(POS_W'(xpos_r)) + $signed(POS_W'(fres));
  assign yc_lo = $signed(POS_W'(ypos_r));
  assign yc_hi = $signed(POS_W'(ypos_r)) + $signed(POS_W'(fres));
  assign xo_lo = (xlo_r > xc_lo) ? xlo_r : xc_lo;
  assign xo_hi = (xhi_r < xc_hi) ? xhi_r : xc_hi;
  assign yo_lo = (ylo_r > yc_lo) ? ylo_r : yc_lo;
  assign yo_hi = (yhi_r < yc_hi) ? yhi_r : yc_hi;
  assign dx    = xo_hi - xo_lo;
  assign dy    = yo_hi - yo_lo;

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      xbase_r <= xb_r * fres;
      xpos_r  <= xb_r * fres;
      ypos_r  <= yb_r * fres;
      fx_r    <= xb_r;
      fy_r    <= yb_r;
    end else if (cmd.step) begin
      if (sts.x_last) begin
        fx_r   <= xb_r;
        xpos_r <= xbase_r;
        fy_r   <= fy_r + 1'b1;
        ypos_r <= ypos_r + PX_W'(fres);
      end else begin
        fx_r   <= fx_r + 1'b1;
        xpos_r <= xpos_r + PX_W'(fres);
      end
    end
    if (cmd.rd_en) begin
      ox_r    <= dx[RES_W-1:0];
      oy_r    <= dy[RES_W-1:0];
      ox_ok_r <= dx > 0;
      oy_ok_r <= dy > 0;
    end
  end

  // Blocked area and free flag
  logic [AREA_W-1:0] acc_r;
  logic [2*RES_W-1:0] area;
  logic              free_r, cell_free;

  assign area      = ox_r * oy_r;
  assign cell_free = (rd_q == CELL_FREE) && ox_ok_r && oy_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      free_r <= 1'b0;
    end else if (cmd.query_go) begin
      acc_r  <= '0;
      free_r <= 1'b0;
    end else if (cmd.eval) begin
      free_r <= cell_free;
      if (rd_q == CELL_BLOCKED && ox_ok_r && oy_ok_r) begin
        acc_r <= acc_r + AREA_W'(area);
      end
    end
  end

  // Output register
  logic             out_valid_r;
  logic [OCC_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= free_r ? OCC_FREE :
                    ((acc_r >= AREA_W'(cres_sq_r)) ? OCC_BLOCKED : OCC_UNKNOWN);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_occupancy = out_data_r;

  // Status to the controller
  always_comb begin
    sts.clr_last  = &clr_cnt_r;
    sts.div_done  = div_done;
    sts.div_busy  = div_busy;
    sts.empty     = (xb_r >= xe_r) || (yb_r >= ye_r);
    sts.x_last    = CNT_W'(fx_r + 1'b1) == xe_r;
    sts.y_last    = CNT_W'(fy_r + 1'b1) == ye_r;
    sts.cell_free = cell_free;
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

@@ design/gdsmp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "grid_overlap_downsampler_defines.svh"
module gdsmp_ctrl import gdsmp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_mode,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t   state_r, state_nxt;
  div_sel_t dcnt_r, dcnt_nxt;
  logic     in_acc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Hold state and divider op count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      dcnt_r  <= DIV_XLO;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    dcnt_nxt  = dcnt_r;
    case (state_r)
      ST_CLEAR:   if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_acc && in_mode) state_nxt = ST_SPAN_LO;
      ST_SPAN_LO: state_nxt = ST_SPAN_HI;
      ST_SPAN_HI: begin
        state_nxt = ST_DIV_GO;
        dcnt_nxt  = DIV_XLO;
      end
      ST_DIV_GO:  state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          if (dcnt_r == DIV_YHI) begin
            state_nxt = ST_BASE;
          end else begin
            state_nxt = ST_DIV_GO;
            dcnt_nxt  = div_sel_t'(dcnt_r + 1'b1);
          end
        end
      end
      ST_BASE:    state_nxt = sts.empty ? ST_DONE : ST_READ;
      ST_READ:    state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (sts.cell_free || (sts.x_last && sts.y_last)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_DONE:    if (sts.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.div_sel = dcnt_r;
    case (state_r)
      ST_CLEAR:   cmd.clr_we = 1'b1;
      ST_IDLE: begin
        cmd.load_we  = in_acc && !in_mode;
        cmd.query_go = in_acc && in_mode;
      end
      ST_SPAN_LO: cmd.span_lo = 1'b1;
      ST_SPAN_HI: cmd.span_hi = 1'b1;
      ST_DIV_GO:  cmd.div_start = 1'b1;
      ST_BASE:    cmd.base = 1'b1;
      ST_READ:    cmd.rd_en = 1'b1;
      ST_EVAL: begin
        cmd.eval = 1'b1;
        cmd.step = !sts.cell_free;
      end
      ST_DONE:    cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  `GDSMP_ASSERT_IMP(a_div_start_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")
  `GDSMP_ASSERT_IMP(a_out_slot_free, cmd.out_load, sts.out_free, "result overwrites a waiting beat")
  `GDSMP_ASSERT_NXT(a_read_then_eval, state_r == ST_READ, state_r == ST_EVAL, "read not evaluated")
  `GDSMP_ASSERT_IMP(a_no_write_walk, cmd.clr_we, !cmd.load_we && !cmd.rd_en, "store port conflict")

endmodule
`default_nettype wire

@@ design/grid_overlap_downsampler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Load beat: written to the cell store in the accept cycle; the block stays ready for the next beat in the cycle after.
// Query beat: four bit-serial divisions set the fine index bounds, then each fine cell in
// the bounds is read from the store and evaluated in turn, stopping at a free overlapping cell.
// One query in flight at a time; result held in an output register.
// Reset (rst_n low, synchronous) restores register defaults, then a clearing pass over
// all 65536 cells sets every cell unknown; no input beat is taken until it finishes.
module grid_overlap_downsampler import gdsmp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_W-1:0]      in_tdata,  // fine_col, fine_row, fine_state, coarse_col, coarse_row
  input  wire logic                 in_tuser,  // mode
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OCC_W-1:0]          out_tdata, // occupancy
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  gdsmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gdsmp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_valid),
    .cfg_idx       (cfg_index),
    .cfg_dat       (cfg_data),
    .in_fine_col   (in_tdata[7:0]),
    .in_fine_row   (in_tdata[15:8]),
    .in_fine_state (in_tdata[17:16]),
    .in_coarse_col (in_tdata[29:18]),
    .in_coarse_row (in_tdata[41:30]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_occupancy (out_tdata)
  );

endmodule
`default_nettype wire

@@ test/grid_overlap_downsampler_checker.sv @@
`timescale 1ns / 1ps
module grid_overlap_downsampler_checker import gdsmp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,  // fine_col, fine_row, fine_state, coarse_col, coarse_row
  input  logic                 in_tuser,  // mode
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OCC_W-1:0]     out_tdata, // occupancy
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   mismatch_count,
  output int                   occupancy_pending
);

  // Shadow copy of the grid and the geometry registers
  logic [1:0]       cell_grid [DEPTH];
  longint           org_x, org_y;
  logic [RES_W-1:0] fine_res, coarse_res;
  logic [8:0]       grid_cols, grid_rows;
  logic [OCC_W-1:0] occupancy_due [$];

  function automatic longint floor_quot(longint a, longint d);
    longint q;
    q = a / d;
    if (a % d != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint ceil_quot(longint a, longint d);
    longint q;
    q = a / d;
    if (a % d != 0 && a > 0) q = q + 1;
    return q;
  endfunction

  function automatic longint clip_index(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint span_overlap(longint a0, longint a1, longint b0, longint b1);
    longint lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // Area-weighted occupancy of one coarse cell
  function automatic logic [OCC_W-1:0] coarse_occupancy(logic [11:0] ccol, logic [11:0] crow);
    longint fr, cr, ncol, nrow, xlo, xhi, ylo, yhi, xb, xe, yb, ye, ox, oy;
    longint unsigned blk_sum;
    logic [1:0] st;
    fr = (fine_res == 0) ? 1 : longint'(fine_res);
    cr = (coarse_res == 0) ? 1 : longint'(coarse_res);
    ncol = (grid_cols > FINE_COLS_MAX) ? FINE_COLS_MAX : longint'(grid_cols);
    nrow = (grid_rows > FINE_ROWS_MAX) ? FINE_ROWS_MAX : longint'(grid_rows);
    blk_sum = 0;
    xlo = org_x + longint'(ccol) * cr;
    xhi = xlo + cr;
    ylo = org_y + longint'(crow) * cr;
    yhi = ylo + cr;
    xb = clip_index(floor_quot(xlo, fr), ncol);
    xe = clip_index(ceil_quot(xhi, fr), ncol);
    yb = clip_index(floor_quot(ylo, fr), nrow);
    ye = clip_index(ceil_quot(yhi, fr), nrow);
    for (longint fy = yb; fy < ye; fy++) begin
      oy = span_overlap(ylo, yhi, fy * fr, fy * fr + fr);
      if (oy <= 0) continue;
      for (longint fx = xb; fx < xe; fx++) begin
        ox = span_overlap(xlo, xhi, fx * fr, fx * fr + fr);
        if (ox <= 0) continue;
        st = cell_grid[fy * FINE_COLS_MAX + fx];
        if (st == CELL_FREE) return OCC_FREE;
        if (st == CELL_BLOCKED) blk_sum += longint'(ox * oy);
      end
    end
    if (blk_sum >= longint'(cr * cr)) return OCC_BLOCKED;
    return OCC_UNKNOWN;
  endfunction

  always @(posedge clk) begin
    logic [OCC_W-1:0] due;
    if (!rst_n) begin
      foreach (cell_grid[i]) cell_grid[i] = CELL_UNKNOWN;
      org_x = 0;
      org_y = 0;
      fine_res = RST_FRES;
      coarse_res = RST_CRES;
      grid_cols = RST_COUNT;
      grid_rows = RST_COUNT;
      occupancy_due.delete();
      mismatch_count = 0;
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OFF_X: org_x = longint'($signed(cfg_data));
          REG_OFF_Y: org_y = longint'($signed(cfg_data));
          REG_FRES:  fine_res = cfg_data[RES_W-1:0];
          REG_CRES:  coarse_res = cfg_data[RES_W-1:0];
          REG_COLS:  grid_cols = cfg_data[8:0];
          REG_ROWS:  grid_rows = cfg_data[8:0];
          default: ;
        endcase
      end
      // Apply a load or predict a query
      if (in_tvalid && in_tready) begin
        if (!in_tuser)
          cell_grid[{in_tdata[15:8], in_tdata[7:0]}] = in_tdata[17:16];
        else
          occupancy_due.push_back(coarse_occupancy(in_tdata[29:18], in_tdata[41:30]));
      end
      // Compare result beats in order
      if (out_tvalid && out_tready) begin
        if (occupancy_due.size() == 0) begin
          $error("occupancy: unexpected beat, actual %0d", $signed(out_tdata));
          mismatch_count++;
        end else begin
          due = occupancy_due.pop_front();
          if (due !== out_tdata) begin
            $error("occupancy: expected %0d, actual %0d", $signed(due), $signed(out_tdata));
            mismatch_count++;
          end
        end
      end
    end
    occupancy_pending = occupancy_due.size();
  end

endmodule

@@ test/grid_overlap_downsampler_test.sv @@
`timescale 1ns / 1ps
module grid_overlap_downsampler_test;
  import gdsmp_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;  // fine_col, fine_row, fine_state, coarse_col, coarse_row
  logic                 in_tuser = 1'b0; // mode
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OCC_W-1:0]     out_tdata;      // occupancy
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  int                   mismatch_count, occupancy_pending;
  longint               cycle_count = 0;
  logic                 calm = 1'b0;
  logic                 hold_req = 1'b0;
  int                   cur_cols, cur_rows, cur_fres, cur_cres;

  grid_overlap_downsampler uut (.*);

  grid_overlap_downsampler_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatch_count, .occupancy_pending
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL grid_overlap_downsampler");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // Present one register write; valid stays high into the next write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_geometry(logic [31:0] ox, logic [31:0] oy, logic [15:0] fres,
                              logic [15:0] cres, logic [8:0] cols, logic [8:0] rows);
    write_reg(REG_OFF_X, ox);
    write_reg(REG_OFF_Y, oy);
    write_reg(REG_FRES, {16'd0, fres});
    write_reg(REG_CRES, {16'd0, cres});
    write_reg(REG_COLS, {23'd0, cols});
    write_reg(REG_ROWS, {23'd0, rows});
    cfg_valid <= 1'b0;
    cur_fres = (fres == 0) ? 1 : fres;
    cur_cres = (cres == 0) ? 1 : cres;
    cur_cols = (cols > 256) ? 256 : cols;
    cur_rows = (rows > 256) ? 256 : rows;
  endtask

  // Present one beat, after a random idle gap unless calm; valid is left high after the beat
  task automatic send_beat(logic mode, logic [7:0] fcol, logic [7:0] frow, logic [1:0] fst,
                           logic [11:0] ccol, logic [11:0] crow);
    if (!calm && $urandom_range(0, 99) < 28) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {6'd0, crow, ccol, fst, frow, fcol};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (occupancy_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Random loads and queries aimed at the grid in use
  task automatic random_items(int count, int ccol_hi);
    int span, pick;
    logic [1:0] st;
    logic [7:0] fc, fr;
    logic [11:0] qc, qr;
    span = ((cur_cols > cur_rows ? cur_cols : cur_rows) * cur_fres) / cur_cres + 2;
    if (span > 4095) span = 4095;
    if (ccol_hi >= 0) span = ccol_hi;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      st = (pick < 60) ? CELL_BLOCKED : (pick < 75) ? CELL_FREE :
           (pick < 90) ? CELL_UNKNOWN : 2'd3;
      if (cur_cols > 0 && $urandom_range(0, 9) < 8) fc = 8'($urandom_range(0, cur_cols - 1));
      else fc = 8'($urandom_range(0, 255));
      if (cur_rows > 0 && $urandom_range(0, 9) < 8) fr = 8'($urandom_range(0, cur_rows - 1));
      else fr = 8'($urandom_range(0, 255));
      if (ccol_hi >= 0 || $urandom_range(0, 9) < 8) begin
        qc = 12'($urandom_range(0, span));
        qr = 12'($urandom_range(0, span));
      end else begin
        qc = 12'($urandom_range(0, 4095));
        qr = 12'($urandom_range(0, 4095));
      end
      send_beat($urandom_range(0, 99) >= 55, fc, fr, st, qc, qr);
    end
    drain();
  endtask

  initial begin
    cur_fres = 1024;
    cur_cres = 4096;
    cur_cols = 256;
    cur_rows = 256;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fill one coarse cell blocked, then probe state codes and corners
    for (int k = 0; k < 16; k++)
      send_beat(1'b0, 8'(k % 4), 8'(k / 4), CELL_BLOCKED, 12'd0, 12'd0);
    send_beat(1'b1, 8'd0, 8'd0, CELL_UNKNOWN, 12'd0, 12'd0);
    send_beat(1'b0, 8'd2, 8'd2, 2'd3, 12'd0, 12'd0);
    send_beat(1'b1, 8'd0, 8'd0, CELL_UNKNOWN, 12'd0, 12'd0);
    send_beat(1'b0, 8'd2, 8'd2, CELL_FREE, 12'd0, 12'd0);
    send_beat(1'b1, 8'd0, 8'd0, CELL_UNKNOWN, 12'd0, 12'd0);
    send_beat(1'b0, 8'd255, 8'd255, CELL_BLOCKED, 12'd0, 12'd0);
    send_beat(1'b1, 8'd0, 8'd0, CELL_UNKNOWN, 12'd63, 12'd63);
    send_beat(1'b1, 8'd0, 8'd0, CELL_UNKNOWN, 12'd4095, 12'd4095);
    drain();

    // Phase with no idling on either side
    calm <= 1'b1;
    set_geometry(-$urandom_range(0, 2047), -$urandom_range(0, 2047), 16'd1024, 16'd2048,
                 9'd256, 9'd256);
    random_items(150, -1);
    calm <= 1'b0;

    // Long receiver hold-off while the sender keeps offering
    hold_req <= 1'b1;
    set_geometry(-$urandom_range(0, 3000), -$urandom_range(0, 3000), 16'd1024,
                 16'(1024 * $urandom_range(1, 4)), 9'($urandom_range(1, 256)),
                 9'($urandom_range(1, 256)));
    random_items(150, -1);

    // Zero resolutions act as one; oversize grid clamps
    set_geometry(32'd0, 32'd0, 16'd0, 16'd0, 9'd511, 9'd511);
    random_items(100, -1);

    set_geometry(-65535 * $urandom_range(0, 3), -65535 * $urandom_range(0, 3), 16'd65535,
                 16'd65535, 9'd511, 9'd300);
    random_items(100, -1);

    set_geometry($urandom_range(0, 10000) - 5000, $urandom_range(0, 10000) - 5000,
                 16'($urandom_range(300, 2000)), 16'($urandom_range(300, 6000)),
                 9'($urandom_range(1, 64)), 9'($urandom_range(1, 64)));
    random_items(120, -1);

    // Offset extremes and an empty grid
    set_geometry(32'h7FFFFFFF, 32'h80000000, 16'd1, 16'd65535, 9'd0, 9'd0);
    random_items(40, -1);

    // A few queries spanning the whole store
    set_geometry(32'd0, 32'd0, 16'd1, 16'd65535, 9'd256, 9'd256);
    random_items(8, 1);

    set_geometry($urandom(), $urandom(), 16'($urandom_range(1, 65535)),
                 16'($urandom_range(1, 65535)), 9'($urandom_range(0, 8)),
                 9'($urandom_range(0, 8)));
    random_items(100, -1);

    set_geometry(-$urandom_range(0, 1023), -$urandom_range(0, 1023), 16'd1024, 16'd1024,
                 9'd256, 9'd1);
    random_items(100, -1);

    // Back to reset geometry
    set_geometry(32'd0, 32'd0, 16'd1024, 16'd4096, 9'd256, 9'd256);
    random_items(100, -1);

    if (mismatch_count == 0 && occupancy_pending == 0) begin
      $display("PASS grid_overlap_downsampler");
    end else begin
      $display("FAIL grid_overlap_downsampler");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/gdsmp_pkg.sv
design/gdsmp_div.sv
design/gdsmp_dp.sv
design/gdsmp_ctrl.sv
design/grid_overlap_downsampler.sv
test/grid_overlap_downsampler_checker.sv
test/grid_overlap_downsampler_test.sv
